[design/smfa_pkg.sv]
package smfa_pkg;

  // Pool geometry
  localparam int SEG_BYTES = 8;
  localparam int SEG_COUNT = 2048;

  // Map organization: each memory row holds the marks of LANES segments
  localparam int LANES    = 8;
  localparam int ROWS     = SEG_COUNT / LANES;
  localparam int LANE_W   = $clog2(LANES);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int MARK_W   = 2;
  localparam int ROW_BITS = LANES * MARK_W;

  // Port field widths
  localparam int OP_W    = 1;
  localparam int BYTES_W = 15;
  localparam int SEG_W   = 11;
  localparam int ADDR_W  = 14;
  localparam int RUN_W   = 12;

  // Internal widths
  localparam int SIDX_W = $clog2(SEG_COUNT);
  localparam int CNT_W  = $clog2(SEG_COUNT + 1);
  localparam int NEED_W = $clog2((1 << BYTES_W) + SEG_BYTES);

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QP_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [MARK_W-1:0] {
    MARK_FREE = 2'd0,
    MARK_HEAD = 2'd1,
    MARK_CONT = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_MARK_WB,
    ST_FREE_RD,
    ST_FREE_WB,
    ST_DONE
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic              fail;
    logic [CNT_W-1:0]  need;
    logic [SIDX_W-1:0] seg;
  } cmd_t;

  // Mark the part of segments first..last that falls in this row, keep the rest.
  function automatic logic [ROW_BITS-1:0] alloc_row(input logic [ROW_W-1:0]    row,
                                                    input logic [ROW_BITS-1:0] old,
                                                    input logic [SIDX_W-1:0]   first,
                                                    input logic [SIDX_W-1:0]   last);
    logic [ROW_BITS-1:0] w;
    logic [SIDX_W-1:0]   seg;
    w = old;
    for (int i = 0; i < LANES; i++) begin
      seg = {row, LANE_W'(i)};
      if (seg == first) begin
        w[i*MARK_W +: MARK_W] = MARK_HEAD;
      end else if (seg > first && seg <= last) begin
        w[i*MARK_W +: MARK_W] = MARK_CONT;
      end
    end
    return w;
  endfunction

endpackage

[design/smfa_ram.sv]
module smfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[design/smfa_queue.sv]
module smfa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  smfa_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output smfa_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);

  smfa_pkg::cmd_t                q_r [smfa_pkg::QDEPTH];
  logic [smfa_pkg::QP_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [smfa_pkg::QP_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [smfa_pkg::QC_W-1:0]     cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == smfa_pkg::QC_W'(smfa_pkg::QDEPTH));
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == smfa_pkg::QP_W'(smfa_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == smfa_pkg::QP_W'(smfa_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[design/smfa_front.sv]
module smfa_front (
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [smfa_pkg::OP_W-1:0]    in_operation,
  input  logic [smfa_pkg::BYTES_W-1:0] in_request_bytes,
  input  logic [smfa_pkg::SEG_W-1:0]   in_free_segment,
  output logic                         push,
  output smfa_pkg::cmd_t               push_cmd
);

  logic [smfa_pkg::NEED_W-1:0] need_w;
  logic                        is_free;
  logic                        alloc_bad;
  logic                        free_bad;

  // Round the byte count up to whole segments
  assign need_w = smfa_pkg::NEED_W'((32'(in_request_bytes) + 32'(smfa_pkg::SEG_BYTES - 1))
                                    / smfa_pkg::SEG_BYTES);

  assign is_free   = (in_operation == smfa_pkg::OP_FREE);
  assign alloc_bad = (need_w == '0) || (32'(need_w) > 32'(smfa_pkg::SEG_COUNT));
  assign free_bad  = (32'(in_free_segment) >= 32'(smfa_pkg::SEG_COUNT));

  assign push = in_valid && !in_stall;

  always_comb begin
    push_cmd.op   = is_free ? smfa_pkg::OP_FREE : smfa_pkg::OP_ALLOC;
    push_cmd.fail = is_free ? free_bad : alloc_bad;
    push_cmd.need = smfa_pkg::CNT_W'(need_w);
    push_cmd.seg  = smfa_pkg::SIDX_W'(in_free_segment);
  end

endmodule

[design/smfa_back.sv]
module smfa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  smfa_pkg::cmd_t              q_head,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_success,
  output logic [smfa_pkg::SEG_W-1:0]  out_start_segment,
  output logic [smfa_pkg::ADDR_W-1:0] out_byte_address,
  output logic [smfa_pkg::RUN_W-1:0]  out_run_segments
);

  localparam logic [smfa_pkg::ROW_W-1:0]  LAST_ROW  = smfa_pkg::ROW_W'(smfa_pkg::ROWS - 1);
  localparam logic [smfa_pkg::LANE_W-1:0] LAST_LANE = smfa_pkg::LANE_W'(smfa_pkg::LANES - 1);

  smfa_pkg::bk_state_t state_r, state_nxt;

  // Map memory
  logic                            ram_we;
  logic [smfa_pkg::ROW_W-1:0]      ram_waddr;
  logic [smfa_pkg::ROW_BITS-1:0]   ram_wdata;
  logic [smfa_pkg::ROW_W-1:0]      ram_raddr;
  logic [smfa_pkg::ROW_BITS-1:0]   ram_rdata;

  // Work registers
  logic [smfa_pkg::ROW_W-1:0]      clr_row_r, clr_row_nxt;
  logic [smfa_pkg::ROW_W-1:0]      scan_row_r, scan_row_nxt;
  logic                            issue_done_r, issue_done_nxt;
  logic                            eval_v_r, eval_v_nxt;
  logic [smfa_pkg::ROW_W-1:0]      eval_row_r, eval_row_nxt;
  logic [smfa_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [smfa_pkg::CNT_W-1:0]      need_r, need_nxt;
  logic [smfa_pkg::SIDX_W-1:0]     first_r, first_nxt;
  logic [smfa_pkg::SIDX_W-1:0]     last_r, last_nxt;
  logic [smfa_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic                            fr_first_r, fr_first_nxt;
  logic [smfa_pkg::CNT_W-1:0]      run_r, run_nxt;

  // Pending result
  logic                            res_ok_r, res_ok_nxt;
  logic [smfa_pkg::SIDX_W-1:0]     res_start_r, res_start_nxt;
  logic [smfa_pkg::CNT_W-1:0]      res_run_r, res_run_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic [smfa_pkg::SEG_W-1:0]      out_start_r, out_start_nxt;
  logic [smfa_pkg::ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [smfa_pkg::RUN_W-1:0]      out_run_r, out_run_nxt;
  logic                            out_free;

  // First-fit row evaluation
  logic [smfa_pkg::CNT_W-1:0]      sc_cnt;
  logic                            sc_found;
  logic [smfa_pkg::LANE_W-1:0]     sc_lane;
  logic [smfa_pkg::SIDX_W-1:0]     sc_last;

  // Free walk row evaluation
  logic [smfa_pkg::ROW_BITS-1:0]   fw_word;
  logic [smfa_pkg::LANE_W:0]       fw_cnt;
  logic                            fw_go;
  logic [smfa_pkg::LANE_W-1:0]     fw_lo;
  logic                            fw_head_ok;

  logic                            mk_partial;

  smfa_ram #(
    .WIDTH (smfa_pkg::ROW_BITS),
    .DEPTH (smfa_pkg::ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Count free segments across one row, stop at the first lane that completes the run
  always_comb begin
    sc_cnt   = count_r;
    sc_found = 1'b0;
    sc_lane  = '0;
    for (int i = 0; i < smfa_pkg::LANES; i++) begin
      if (smfa_pkg::mark_t'(ram_rdata[i*smfa_pkg::MARK_W +: smfa_pkg::MARK_W])
          == smfa_pkg::MARK_FREE) begin
        sc_cnt = sc_cnt + 1'b1;
      end else begin
        sc_cnt = '0;
      end
      if (!sc_found && sc_cnt == need_r) begin
        sc_found = 1'b1;
        sc_lane  = smfa_pkg::LANE_W'(i);
      end
    end
  end

  assign sc_last = {eval_row_r, sc_lane};

  // Clear the head and the continuations that follow it within this row
  always_comb begin
    fw_lo      = fr_first_r ? first_r[smfa_pkg::LANE_W-1:0] : '0;
    fw_word    = ram_rdata;
    fw_cnt     = '0;
    fw_go      = 1'b1;
    fw_head_ok = (smfa_pkg::mark_t'(ram_rdata[{fw_lo, 1'b0} +: smfa_pkg::MARK_W])
                  == smfa_pkg::MARK_HEAD);
    for (int i = 0; i < smfa_pkg::LANES; i++) begin
      if (smfa_pkg::LANE_W'(i) < fw_lo) begin
        fw_word[i*smfa_pkg::MARK_W +: smfa_pkg::MARK_W] =
          ram_rdata[i*smfa_pkg::MARK_W +: smfa_pkg::MARK_W];
      end else if (fr_first_r && smfa_pkg::LANE_W'(i) == fw_lo) begin
        fw_word[i*smfa_pkg::MARK_W +: smfa_pkg::MARK_W] = smfa_pkg::MARK_FREE;
        fw_cnt = fw_cnt + 1'b1;
      end else if (fw_go && smfa_pkg::mark_t'(ram_rdata[i*smfa_pkg::MARK_W +: smfa_pkg::MARK_W])
                   == smfa_pkg::MARK_CONT) begin
        fw_word[i*smfa_pkg::MARK_W +: smfa_pkg::MARK_W] = smfa_pkg::MARK_FREE;
        fw_cnt = fw_cnt + 1'b1;
      end else begin
        fw_go = 1'b0;
      end
    end
  end

  // Rows at either end of a run that share lanes with other runs need read-modify-write
  assign mk_partial =
    (row_r == first_r[smfa_pkg::SIDX_W-1:smfa_pkg::LANE_W] &&
     first_r[smfa_pkg::LANE_W-1:0] != '0) ||
    (row_r == last_r[smfa_pkg::SIDX_W-1:smfa_pkg::LANE_W] &&
     last_r[smfa_pkg::LANE_W-1:0] != LAST_LANE);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    ram_we         = 1'b0;
    ram_waddr      = row_r;
    ram_wdata      = '0;
    ram_raddr      = row_r;
    q_pop          = 1'b0;
    clr_row_nxt    = clr_row_r;
    scan_row_nxt   = scan_row_r;
    issue_done_nxt = issue_done_r;
    eval_v_nxt     = 1'b0;
    eval_row_nxt   = eval_row_r;
    count_nxt      = count_r;
    need_nxt       = need_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    row_nxt        = row_r;
    fr_first_nxt   = fr_first_r;
    run_nxt        = run_r;
    res_ok_nxt     = res_ok_r;
    res_start_nxt  = res_start_r;
    res_run_nxt    = res_run_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_ok_nxt     = out_ok_r;
    out_start_nxt  = out_start_r;
    out_addr_nxt   = out_addr_r;
    out_run_nxt    = out_run_r;

    case (state_r)
      smfa_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row_r;
        ram_wdata = '0;
        if (clr_row_r == LAST_ROW) begin
          state_nxt = smfa_pkg::ST_IDLE;
        end else begin
          clr_row_nxt = clr_row_r + 1'b1;
        end
      end

      smfa_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          need_nxt  = q_head.need;
          first_nxt = q_head.seg;
          if (q_head.fail) begin
            res_ok_nxt    = 1'b0;
            res_start_nxt = '0;
            res_run_nxt   = '0;
            state_nxt     = smfa_pkg::ST_DONE;
          end else if (q_head.op == smfa_pkg::OP_FREE) begin
            row_nxt      = q_head.seg[smfa_pkg::SIDX_W-1:smfa_pkg::LANE_W];
            fr_first_nxt = 1'b1;
            run_nxt      = '0;
            state_nxt    = smfa_pkg::ST_FREE_RD;
          end else begin
            scan_row_nxt   = '0;
            issue_done_nxt = 1'b0;
            count_nxt      = '0;
            state_nxt      = smfa_pkg::ST_SCAN;
          end
        end
      end

      smfa_pkg::ST_SCAN: begin
        // Read one row ahead of the row being evaluated
        ram_raddr    = scan_row_r;
        eval_v_nxt   = !issue_done_r;
        eval_row_nxt = scan_row_r;
        if (!issue_done_r) begin
          if (scan_row_r == LAST_ROW) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_row_nxt = scan_row_r + 1'b1;
          end
        end
        if (eval_v_r) begin
          if (sc_found) begin
            eval_v_nxt = 1'b0;
            last_nxt   = sc_last;
            first_nxt  = smfa_pkg::SIDX_W'(32'(sc_last) + 32'd1 - 32'(need_r));
            row_nxt    = first_nxt[smfa_pkg::SIDX_W-1:smfa_pkg::LANE_W];
            state_nxt  = smfa_pkg::ST_MARK;
          end else begin
            count_nxt = sc_cnt;
            if (eval_row_r == LAST_ROW) begin
              eval_v_nxt    = 1'b0;
              res_ok_nxt    = 1'b0;
              res_start_nxt = '0;
              res_run_nxt   = '0;
              state_nxt     = smfa_pkg::ST_DONE;
            end
          end
        end
      end

      smfa_pkg::ST_MARK: begin
        if (mk_partial) begin
          ram_raddr = row_r;
          state_nxt = smfa_pkg::ST_MARK_WB;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = row_r;
          ram_wdata = smfa_pkg::alloc_row(row_r, '0, first_r, last_r);
          if (row_r == last_r[smfa_pkg::SIDX_W-1:smfa_pkg::LANE_W]) begin
            res_ok_nxt    = 1'b1;
            res_start_nxt = first_r;
            res_run_nxt   = need_r;
            state_nxt     = smfa_pkg::ST_DONE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end

      smfa_pkg::ST_MARK_WB: begin
        ram_we    = 1'b1;
        ram_waddr = row_r;
        ram_wdata = smfa_pkg::alloc_row(row_r, ram_rdata, first_r, last_r);
        if (row_r == last_r[smfa_pkg::SIDX_W-1:smfa_pkg::LANE_W]) begin
          res_ok_nxt    = 1'b1;
          res_start_nxt = first_r;
          res_run_nxt   = need_r;
          state_nxt     = smfa_pkg::ST_DONE;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = smfa_pkg::ST_MARK;
        end
      end

      smfa_pkg::ST_FREE_RD: begin
        ram_raddr = row_r;
        state_nxt = smfa_pkg::ST_FREE_WB;
      end

      smfa_pkg::ST_FREE_WB: begin
        if (fr_first_r && !fw_head_ok) begin
          res_ok_nxt    = 1'b0;
          res_start_nxt = '0;
          res_run_nxt   = '0;
          state_nxt     = smfa_pkg::ST_DONE;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = row_r;
          ram_wdata    = fw_word;
          run_nxt      = run_r + smfa_pkg::CNT_W'(fw_cnt);
          fr_first_nxt = 1'b0;
          if (fw_go && row_r != LAST_ROW) begin
            row_nxt   = row_r + 1'b1;
            state_nxt = smfa_pkg::ST_FREE_RD;
          end else begin
            res_ok_nxt    = 1'b1;
            res_start_nxt = '0;
            res_run_nxt   = run_nxt;
            state_nxt     = smfa_pkg::ST_DONE;
          end
        end
      end

      smfa_pkg::ST_DONE: begin
        // Hold the result until the output register has room
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_start_nxt = smfa_pkg::SEG_W'(res_start_r);
          out_addr_nxt  = smfa_pkg::ADDR_W'(32'(res_start_r) * smfa_pkg::SEG_BYTES);
          out_run_nxt   = smfa_pkg::RUN_W'(res_run_r);
          state_nxt     = smfa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = smfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smfa_pkg::ST_CLEAR;
      clr_row_r   <= '0;
      eval_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      eval_v_r    <= eval_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_row_r   <= scan_row_nxt;
    issue_done_r <= issue_done_nxt;
    eval_row_r   <= eval_row_nxt;
    count_r      <= count_nxt;
    need_r       <= need_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    row_r        <= row_nxt;
    fr_first_r   <= fr_first_nxt;
    run_r        <= run_nxt;
    res_ok_r     <= res_ok_nxt;
    res_start_r  <= res_start_nxt;
    res_run_r    <= res_run_nxt;
    out_ok_r     <= out_ok_nxt;
    out_start_r  <= out_start_nxt;
    out_addr_r   <= out_addr_nxt;
    out_run_r    <= out_run_nxt;
  end

  assign clearing          = (state_r == smfa_pkg::ST_CLEAR);
  assign out_valid         = out_valid_r;
  assign out_success       = out_ok_r;
  assign out_start_segment = out_start_r;
  assign out_byte_address  = out_addr_r;
  assign out_run_segments  = out_run_r;

endmodule

[design/segment_map_first_fit_allocator_core.sv]
// Flow: a queued request is popped by the back end when idle and worked on the map; its result
//   waits in the done state for the output register. An allocate reads a row ahead and scans
//   map rows (8 segments each) up to the row where the run completes, then writes each fully
//   covered row and reads then writes each shared row; a free reads then writes each row.
// Requests: one request in the back end at a time; a 2-deep queue holds those that wait.
// Reset: synchronous, active low; a clearing pass marks the whole map free while input stalls.
module segment_map_first_fit_allocator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [smfa_pkg::OP_W-1:0]    in_operation,
  input  logic [smfa_pkg::BYTES_W-1:0] in_request_bytes,
  input  logic [smfa_pkg::SEG_W-1:0]   in_free_segment,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_success,
  output logic [smfa_pkg::SEG_W-1:0]   out_start_segment,
  output logic [smfa_pkg::ADDR_W-1:0]  out_byte_address,
  output logic [smfa_pkg::RUN_W-1:0]   out_run_segments
);

  logic           q_push;
  smfa_pkg::cmd_t q_push_cmd;
  logic           q_pop;
  smfa_pkg::cmd_t q_head;
  logic           q_empty;
  logic           q_full;
  logic           clearing;

  // Hold requests while the queue is full or the map is being cleared
  assign in_stall = q_full || clearing;

  smfa_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_request_bytes (in_request_bytes),
    .in_free_segment  (in_free_segment),
    .push             (q_push),
    .push_cmd         (q_push_cmd)
  );

  smfa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  smfa_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_success       (out_success),
    .out_start_segment (out_start_segment),
    .out_byte_address  (out_byte_address),
    .out_run_segments  (out_run_segments)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_success) |->
      (out_start_segment == '0 && out_byte_address == '0 && out_run_segments == '0))
    else $error("failed request carries nonzero fields");

  a_ok_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_success) |-> (out_run_segments != '0))
    else $error("successful request reports an empty run");

  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_address ==
                   smfa_pkg::ADDR_W'(32'(out_start_segment) * smfa_pkg::SEG_BYTES)))
    else $error("byte address does not match start segment");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (q_empty && !out_valid))
    else $error("activity during map clearing pass");

endmodule

[tb/smfa_map_checker.sv]
module smfa_map_checker
  import smfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [BYTES_W-1:0] in_request_bytes,
  input  logic [SEG_W-1:0]   in_free_segment,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_success,
  input  logic [SEG_W-1:0]   out_start_segment,
  input  logic [ADDR_W-1:0]  out_byte_address,
  input  logic [RUN_W-1:0]   out_run_segments,
  output int                 mismatch_count,
  output int                 results_due
);

  typedef struct packed {
    logic              success;
    logic [SEG_W-1:0]  start;
    logic [ADDR_W-1:0] addr;
    logic [RUN_W-1:0]  run;
  } map_result_t;

  mark_t       seg_map [SEG_COUNT];
  map_result_t awaited_results [$];

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  // Apply one request to the shadow segment map and return the result it owes.
  function automatic map_result_t apply_map_request(input op_t               op,
                                                    input logic [BYTES_W-1:0] bytes,
                                                    input logic [SEG_W-1:0]   seg);
    map_result_t r;
    int          need;
    int          count;
    int          first;
    int          k;
    int          m;
    int          run;
    logic        found;
    r = '0;
    if (op == OP_ALLOC) begin
      need  = (int'(bytes) + SEG_BYTES - 1) / SEG_BYTES;
      found = 1'b0;
      if (need >= 1 && need <= SEG_COUNT) begin
        count = 0;
        for (k = 0; k < SEG_COUNT && !found; k++) begin
          if (seg_map[k] == MARK_FREE) begin
            count++;
          end else begin
            count = 0;
          end
          if (count == need) begin
            found = 1'b1;
            first = k + 1 - need;
            seg_map[first] = MARK_HEAD;
            for (m = first + 1; m <= k; m++) begin
              seg_map[m] = MARK_CONT;
            end
            r.success = 1'b1;
            r.start   = SEG_W'(first);
            r.addr    = ADDR_W'(first * SEG_BYTES);
            r.run     = RUN_W'(need);
          end
        end
      end
    end else if (seg_map[seg] == MARK_HEAD) begin
      seg_map[seg] = MARK_FREE;
      run = 1;
      m   = int'(seg) + 1;
      while (m < SEG_COUNT && seg_map[m] == MARK_CONT) begin
        seg_map[m] = MARK_FREE;
        run++;
        m++;
      end
      r.success = 1'b1;
      r.run     = RUN_W'(run);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    map_result_t want;
    map_result_t got;
    if (!rst_n) begin
      foreach (seg_map[i]) seg_map[i] = MARK_FREE;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(apply_map_request(op_t'(in_operation),
                                                    in_request_bytes, in_free_segment));
      end
      if (out_valid && !out_stall) begin
        got = '{out_success, out_start_segment, out_byte_address, out_run_segments};
        if (awaited_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected result ok=%0d start=%0d addr=%0d run=%0d", $realtime,
                     got.success, got.start, got.addr, got.run);
          end
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (want !== got) begin
            if (mismatch_count < 10) begin
              $display("%0t: result mismatch, expected ok=%0d start=%0d addr=%0d run=%0d",
                       $realtime, want.success, want.start, want.addr, want.run);
              $display("%0t:                  actual ok=%0d start=%0d addr=%0d run=%0d",
                       $realtime, got.success, got.start, got.addr, got.run);
            end
            mismatch_count++;
          end
        end
      end
    end
    results_due = awaited_results.size();
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  import smfa_pkg::*;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int IDLE_LIMIT      = 20000;
  localparam int DRAIN_CYCLES    = 1200;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    in_operation;
  logic [BYTES_W-1:0] in_request_bytes;
  logic [SEG_W-1:0]   in_free_segment;
  logic               out_valid;
  logic               out_stall;
  logic               out_success;
  logic [SEG_W-1:0]   out_start_segment;
  logic [ADDR_W-1:0]  out_byte_address;
  logic [RUN_W-1:0]   out_run_segments;

  int   mismatch_count;
  int   results_due;
  int   idle_cycles;
  bit   quiet;
  op_t  ops_in_flight [$];
  int   live_heads [$];

  segment_map_first_fit_allocator_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_request_bytes  (in_request_bytes),
    .in_free_segment   (in_free_segment),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_success       (out_success),
    .out_start_segment (out_start_segment),
    .out_byte_address  (out_byte_address),
    .out_run_segments  (out_run_segments)
  );

  smfa_map_checker checker_inst (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_request_bytes  (in_request_bytes),
    .in_free_segment   (in_free_segment),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_success       (out_success),
    .out_start_segment (out_start_segment),
    .out_byte_address  (out_byte_address),
    .out_run_segments  (out_run_segments),
    .mismatch_count    (mismatch_count),
    .results_due       (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input op_t op, input logic [BYTES_W-1:0] bytes,
                              input logic [SEG_W-1:0] seg);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_request_bytes <= bytes;
    in_free_segment  <= seg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ops_in_flight.push_back(op);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Track heads of successful allocations so frees can target live runs.
  always @(posedge clk) begin
    op_t done_op;
    if (rst_n && out_valid && !out_stall && ops_in_flight.size() != 0) begin
      done_op = ops_in_flight.pop_front();
      if (done_op == OP_ALLOC && out_success) begin
        live_heads.push_back(int'(out_start_segment));
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = pick_gap();
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL segment_map_first_fit_allocator_core");
      $finish;
    end
  end

  initial begin
    int   r;
    int   idx;
    int   seg;
    logic [BYTES_W-1:0] bytes;
    idle_cycles      = 0;
    quiet            = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_ALLOC;
    in_request_bytes = '0;
    in_free_segment  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Edge cases: size limits, whole-map runs, holes and non-head frees.
    send_request(OP_ALLOC, 15'd0, 11'd2047);
    send_request(OP_ALLOC, 15'd32767, 11'd0);
    send_request(OP_ALLOC, 15'd16385, 11'd0);
    send_request(OP_ALLOC, 15'd16384, 11'd0);
    send_request(OP_ALLOC, 15'd1, 11'd0);
    send_request(OP_FREE, 15'd32767, 11'd1);
    send_request(OP_FREE, 15'd0, 11'd0);
    send_request(OP_ALLOC, 15'd1, 11'd0);
    send_request(OP_ALLOC, 15'd8, 11'd0);
    send_request(OP_ALLOC, 15'd9, 11'd0);
    send_request(OP_FREE, 15'd0, 11'd1);
    send_request(OP_ALLOC, 15'd3, 11'd0);
    send_request(OP_FREE, 15'd0, 11'd5);
    send_request(OP_FREE, 15'd0, 11'd3);
    send_request(OP_ALLOC, 15'd16376, 11'd0);
    send_request(OP_ALLOC, 15'd16352, 11'd0);
    send_request(OP_FREE, 15'd0, 11'd2047);
    send_request(OP_FREE, 15'd0, 11'd4);
    send_request(OP_ALLOC, 15'd16360, 11'd0);
    send_request(OP_FREE, 15'd0, 11'd0);
    send_request(OP_FREE, 15'd0, 11'd1);
    send_request(OP_FREE, 15'd0, 11'd2);
    send_request(OP_FREE, 15'd0, 11'd0);
    send_request(OP_ALLOC, 15'd16384, 11'd0);
    send_request(OP_FREE, 15'd0, 11'd0);
    wait_for_drain();
    live_heads.delete();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 150 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_REQUESTS / 2) begin
        wait_for_drain();
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          bytes = BYTES_W'($urandom_range(1, 64));
        end else if (r < 90) begin
          bytes = BYTES_W'($urandom_range(65, 1024));
        end else if (r < 97) begin
          bytes = BYTES_W'($urandom_range(1025, 16384));
        end else begin
          bytes = BYTES_W'($urandom_range(0, 32767));
        end
        send_request(OP_ALLOC, bytes, SEG_W'($urandom_range(0, 2047)));
      end else begin
        r = $urandom_range(0, 99);
        if (live_heads.size() != 0 && r < 80) begin
          idx = $urandom_range(0, live_heads.size() - 1);
          seg = live_heads[idx];
          live_heads.delete(idx);
          // Sometimes aim just past the head to hit a continuation.
          if (r < 8) begin
            seg = (seg + $urandom_range(1, 3)) % SEG_COUNT;
          end
        end else begin
          seg = $urandom_range(0, 2047);
        end
        send_request(OP_FREE, BYTES_W'($urandom_range(0, 32767)), SEG_W'(seg));
      end
    end
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && results_due == 0) begin
      $display("PASS segment_map_first_fit_allocator_core");
    end else begin
      $display("FAIL segment_map_first_fit_allocator_core");
    end
    $finish;
  end

endmodule
